FILE: src/bcse_pkg.sv
// Shared types, operation codes and the open-circuit-voltage curve for the
// battery charge-state estimator. No dependencies.
package bcse_pkg;

  localparam int DIV_DW = 46;  // dividend and quotient width of the shared divider
  localparam int DIV_VW = 32;  // divisor width
  localparam int DIV_CW = 6;   // divider step counter width
  localparam int IDX_W  = 5;   // curve index width, curve has at most 32 points

  localparam logic [30:0] FULL_CHARGE_RST = 31'd6328800;
  localparam logic [9:0]  STEP_MS_RST     = 10'd50;
  localparam logic [7:0]  SOC_FULL        = 8'd200;

  // Reciprocals for the constant divides. Each is ceil(2^k / d), and the
  // rounding error stays small enough that the top bits of the product give
  // the exact truncated quotient over the operand range used.
  localparam logic [26:0] RECIP_1000   = 27'd68719477;    // 2^36 / 1000, for x < 2^26
  localparam logic [27:0] RECIP_10K_LO = 28'd219902326;   // 2^41 / 10000, for x < 2^27
  localparam logic [31:0] RECIP_10K_HI = 32'd3518437209;  // 2^45 / 10000, for x < 2^31

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;

  localparam logic CFG_FULL_CHARGE = 1'b0;
  localparam logic CFG_STEP_MS     = 1'b1;

  typedef logic [3:0] op_t;
  localparam op_t OP_IDLE        = 4'd0;
  localparam op_t OP_ACCEPT      = 4'd1;
  localparam op_t OP_DIV_DELTA   = 4'd2;
  localparam op_t OP_APPLY_DELTA = 4'd3;
  localparam op_t OP_SUM         = 4'd4;
  localparam op_t OP_TAKE_SOC    = 4'd5;
  localparam op_t OP_EMIT        = 4'd6;
  localparam op_t OP_SEARCH      = 4'd7;
  localparam op_t OP_DIV_INTERP  = 4'd8;
  localparam op_t OP_TAKE_S      = 4'd9;
  localparam op_t OP_DIV_INIT    = 4'd10;
  localparam op_t OP_TAKE_INIT   = 4'd11;
  localparam op_t OP_FINAL       = 4'd12;
  localparam op_t OP_RECIP_DELTA = 4'd13;
  localparam op_t OP_RECIP_INIT  = 4'd14;

  typedef struct packed {
    logic div_done;   // divider holds a finished quotient
    logic pred_div;   // predict sum is in range and needs the SOC divide
    logic full_nz;    // full charge register is nonzero
    logic found;      // current curve interval holds the voltage
    logic last;       // current curve interval is the last one
    logic out_free;   // output register can take a beat this cycle
  } dp_stat_t;

  function automatic logic [15:0] bcse_curve(input logic [IDX_W-1:0] idx);
    logic [15:0] pt;
    unique case (idx)
      5'd0:    pt = 16'd25000;
      5'd1:    pt = 16'd29755;
      5'd2:    pt = 16'd31796;
      5'd3:    pt = 16'd32849;
      5'd4:    pt = 16'd33836;
      5'd5:    pt = 16'd34758;
      5'd6:    pt = 16'd35614;
      5'd7:    pt = 16'd36338;
      5'd8:    pt = 16'd37194;
      5'd9:    pt = 16'd37948;
      default: pt = 16'd42000;
    endcase
    return pt;
  endfunction

endpackage

FILE: src/battery_charge_state_estimator_unit.sv
// Top level of the battery charge-state estimator (coulomb counter with
// open-circuit-voltage correction). Depends on bcse_pkg, bcse_ctrl, bcse_dp.
//
// Each input beat is either a predict tick or a voltage correction and
// yields exactly one state-of-charge beat in half-percent steps (200 is
// full). A predict tick integrates pack current times step_ms / 1000 into
// the integrator, adds it to the charge lost and clamps to the range
// 0..full_charge; a correction clears the integrator, walks the voltage
// curve one interval per cycle, interpolates a charge fraction and rebuilds
// the charge lost from it. The divides by the constants 1000 and 10000 use
// reciprocal multiplication with registered products. The divides by
// full_charge and by the width of a curve interval share one restoring
// divider that produces one quotient bit per cycle, and that divider sets
// the item time. A predict runs one divide unless it clamps or full_charge
// is zero, and a correction walks the curve of up to CURVE_POINTS-1
// intervals and runs up to two divides, or none when the voltage lies in
// no interval. One item is in work at a time; in_stall stays high from
// acceptance until its result has moved into the output register, so the
// next item is taken while that result still waits on out_stall.
// Configuration must be written through cfg_we, cfg_index and cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module battery_charge_state_estimator_unit
  import bcse_pkg::*;
#(
  parameter int CURVE_POINTS = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [15:0] in_pack_current,
  input  logic [15:0]        in_min_cell_voltage,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_soc
);

  op_t      op;
  dp_stat_t stat;

  // The sequencer only issues operations; all data state lives in the datapath.
  bcse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .op         (op)
  );

  bcse_dp #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_command          (in_command),
    .in_pack_current     (in_pack_current),
    .in_min_cell_voltage (in_min_cell_voltage),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_soc             (out_soc),
    .op                  (op),
    .stat                (stat)
  );

endmodule

FILE: src/bcse_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bcse_pkg for its widths.
module bcse_div
  import bcse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output logic              done,
  output logic [DIV_DW-1:0] quotient
);

  localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(DIV_DW - 1);

  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_VW-1:0] dvs_r, dvs_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_VW:0]   shifted;
  logic [DIV_VW:0]   trial;

  assign shifted = {rem_r, quo_r[DIV_DW-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (!trial[DIV_VW]) begin
        rem_nxt = trial[DIV_VW-1:0];
        quo_nxt = {quo_r[DIV_DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_VW-1:0];
        quo_nxt = {quo_r[DIV_DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider reports done while still stepping");

endmodule

FILE: src/bcse_ctrl.sv
// Sequencer for the charge-state estimator: steps the datapath through
// predict and correction items. Depends on bcse_pkg.
module bcse_ctrl
  import bcse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_stall,
  input  dp_stat_t stat,
  output op_t      op
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DELTA    = 4'd1;
  localparam logic [3:0] S_DELTA_Q  = 4'd2;
  localparam logic [3:0] S_SUM      = 4'd3;
  localparam logic [3:0] S_SOC_W    = 4'd4;
  localparam logic [3:0] S_EMIT     = 4'd5;
  localparam logic [3:0] S_SEARCH   = 4'd6;
  localparam logic [3:0] S_INTERP   = 4'd7;
  localparam logic [3:0] S_INTERP_W = 4'd8;
  localparam logic [3:0] S_INIT     = 4'd9;
  localparam logic [3:0] S_INIT_Q   = 4'd10;
  localparam logic [3:0] S_FINAL    = 4'd11;
  localparam logic [3:0] S_APPLY    = 4'd12;
  localparam logic [3:0] S_INIT_T   = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_ACCEPT;
          state_nxt = (in_command == CMD_CORRECT) ? S_SEARCH : S_DELTA;
        end
      end
      S_DELTA: begin
        op        = OP_DIV_DELTA;
        state_nxt = S_DELTA_Q;
      end
      S_DELTA_Q: begin
        op        = OP_RECIP_DELTA;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        op        = OP_APPLY_DELTA;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        op        = OP_SUM;
        state_nxt = stat.pred_div ? S_SOC_W : S_EMIT;
      end
      S_SOC_W: begin
        if (stat.div_done) begin
          op        = OP_TAKE_SOC;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_SEARCH: begin
        op = OP_SEARCH;
        if (stat.found) begin
          state_nxt = S_INTERP;
        end else if (stat.last) begin
          state_nxt = S_EMIT;
        end
      end
      S_INTERP: begin
        op        = OP_DIV_INTERP;
        state_nxt = S_INTERP_W;
      end
      S_INTERP_W: begin
        if (stat.div_done) begin
          op        = OP_TAKE_S;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        op        = OP_DIV_INIT;
        state_nxt = S_INIT_Q;
      end
      S_INIT_Q: begin
        op        = OP_RECIP_INIT;
        state_nxt = S_INIT_T;
      end
      S_INIT_T: begin
        op        = OP_TAKE_INIT;
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        op        = OP_FINAL;
        state_nxt = stat.full_nz ? S_SOC_W : S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_predict_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == CMD_PREDICT) |=> state_r == S_DELTA)
    else $error("accepted predict beat did not start the delta divide");

endmodule

FILE: src/bcse_dp.sv
// Datapath of the charge-state estimator: configuration, charge state,
// curve search, operand products and the output register.
// Depends on bcse_pkg and bcse_div.
module bcse_dp
  import bcse_pkg::*;
#(
  parameter int CURVE_POINTS = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_command,
  input  logic signed [15:0] in_pack_current,
  input  logic [15:0]        in_min_cell_voltage,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_soc,
  input  op_t                op,
  output dp_stat_t           stat
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CURVE_POINTS - 2);

  logic [30:0]        full_r, full_nxt;
  logic [9:0]         step_r, step_nxt;
  logic [31:0]        cl_r, cl_nxt;
  logic [31:0]        ig_r, ig_nxt;
  logic signed [15:0] cur_r, cur_nxt;
  logic [15:0]        volt_r, volt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               neg_r, neg_nxt;
  logic [26:0]        mag_r, mag_nxt;
  logic [16:0]        dq_r, dq_nxt;
  logic [14:0]        s_r, s_nxt;
  logic [31:0]        sq_r, sq_nxt;
  logic [26:0]        sr_r, sr_nxt;
  logic [13:0]        srq_r, srq_nxt;
  logic [17:0]        fq_r;
  logic [13:0]        fr_r;
  logic [30:0]        init_r, init_nxt;
  logic [7:0]         res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_soc_r, out_soc_nxt;

  logic               div_start;
  logic [DIV_DW-1:0]  div_dividend;
  logic [DIV_VW-1:0]  div_divisor;
  logic               div_done;
  logic [DIV_DW-1:0]  div_q;

  logic signed [26:0] cur_prod;
  logic [26:0]        cur_mag;
  logic [53:0]        mag_prod;
  logic [31:0]        delta;
  logic signed [32:0] sum;
  logic               sum_hi;
  logic               sum_lo;
  logic               full_nz;
  logic [30:0]        margin;
  logic [38:0]        margin_x;
  logic [15:0]        lo_pt;
  logic [15:0]        hi_pt;
  logic               found;
  logic [25:0]        interp_num;
  logic [62:0]        fq_prod;
  logic [31:0]        fq_x;
  logic [31:0]        fr_full;
  logic [54:0]        sr_prod;
  logic [31:0]        init_sum;
  logic [38:0]        init_x;

  // Operand products; each is registered before use.
  assign cur_prod   = cur_r * $signed({1'b0, step_r});
  assign cur_mag    = cur_prod[26] ? 27'(-cur_prod) : 27'(cur_prod);
  assign mag_prod   = mag_r * RECIP_1000;
  assign delta      = {15'd0, dq_r};
  assign sum        = $signed({cl_r[31], cl_r}) + $signed({ig_r[31], ig_r});
  assign sum_hi     = sum > $signed({2'b00, full_r});
  assign sum_lo     = sum[32];
  assign full_nz    = (full_r != 31'd0);
  assign margin     = full_r - sum[30:0];
  assign margin_x   = margin * 8'd200;
  assign lo_pt      = bcse_curve(idx_r);
  assign hi_pt      = bcse_curve(idx_r + 1'b1);
  assign found      = (volt_r > lo_pt) && (volt_r < hi_pt);
  assign interp_num = (volt_r - lo_pt) * 10'd1000;
  assign init_x     = init_r * 8'd200;

  // Full charge split as q * 10000 + r, so that s * full / 10000 becomes
  // s * q plus a small divide of s * r. q is registered from full_r and r
  // from q, long before a correction needs them.
  assign fq_prod    = full_r * RECIP_10K_HI;
  assign fq_x       = fq_r * 14'd10000;
  assign fr_full    = {1'b0, full_r} - fq_x;
  assign sr_prod    = sr_r * RECIP_10K_LO;
  assign init_sum   = sq_r + {18'd0, srq_r};

  always_comb begin
    full_nxt      = full_r;
    step_nxt      = step_r;
    cl_nxt        = cl_r;
    ig_nxt        = ig_r;
    cur_nxt       = cur_r;
    volt_nxt      = volt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    dq_nxt        = dq_r;
    s_nxt         = s_r;
    sq_nxt        = sq_r;
    sr_nxt        = sr_r;
    srq_nxt       = srq_r;
    init_nxt      = init_r;
    res_nxt       = res_r;
    out_soc_nxt   = out_soc_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL_CHARGE: full_nxt = cfg_wdata;
        CFG_STEP_MS:     step_nxt = cfg_wdata[9:0];
        default:         full_nxt = full_r;
      endcase
    end

    unique case (op)
      OP_ACCEPT: begin
        cur_nxt  = in_pack_current;
        volt_nxt = in_min_cell_voltage;
        idx_nxt  = '0;
        if (in_command == CMD_CORRECT) begin
          ig_nxt = '0;
        end
      end
      OP_DIV_DELTA: begin
        mag_nxt = cur_mag;
        neg_nxt = cur_prod[26];
      end
      OP_RECIP_DELTA: begin
        dq_nxt = mag_prod[52:36];
      end
      OP_APPLY_DELTA: begin
        ig_nxt = neg_r ? (ig_r - delta) : (ig_r + delta);
      end
      OP_SUM: begin
        if (sum_hi) begin
          res_nxt = 8'd0;
          cl_nxt  = {1'b0, full_r};
          ig_nxt  = '0;
        end else if (sum_lo) begin
          res_nxt = SOC_FULL;
          cl_nxt  = '0;
          ig_nxt  = '0;
        end else if (!full_nz) begin
          res_nxt = 8'd0;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_DW'(margin_x);
          div_divisor  = DIV_VW'(full_r);
        end
      end
      OP_TAKE_SOC: begin
        res_nxt = div_q[7:0];
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_soc_nxt   = res_r;
      end
      OP_SEARCH: begin
        if (!found) begin
          if (idx_r == LAST_IDX) begin
            res_nxt = SOC_FULL;
            cl_nxt  = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      OP_DIV_INTERP: begin
        div_start    = 1'b1;
        div_dividend = DIV_DW'(interp_num);
        div_divisor  = DIV_VW'(hi_pt - lo_pt);
      end
      OP_TAKE_S: begin
        s_nxt = 15'(idx_r) * 15'd1000 + 15'(div_q[9:0]);
      end
      OP_DIV_INIT: begin
        sq_nxt = 32'(s_r) * 32'(fq_r);
        sr_nxt = 27'(s_r) * 27'(fr_r);
      end
      OP_RECIP_INIT: begin
        srq_nxt = sr_prod[54:41];
      end
      OP_TAKE_INIT: begin
        init_nxt = init_sum[30:0];
        cl_nxt   = {1'b0, full_r} - init_sum;
      end
      OP_FINAL: begin
        if (full_nz) begin
          div_start    = 1'b1;
          div_dividend = DIV_DW'(init_x);
          div_divisor  = DIV_VW'(full_r);
        end else begin
          res_nxt = 8'd0;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    volt_r    <= volt_nxt;
    idx_r     <= idx_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    dq_r      <= dq_nxt;
    s_r       <= s_nxt;
    sq_r      <= sq_nxt;
    sr_r      <= sr_nxt;
    srq_r     <= srq_nxt;
    fq_r      <= fq_prod[62:45];
    fr_r      <= fr_full[13:0];
    init_r    <= init_nxt;
    res_r     <= res_nxt;
    out_soc_r <= out_soc_nxt;
    if (!rst_n) begin
      full_r      <= FULL_CHARGE_RST;
      step_r      <= STEP_MS_RST;
      cl_r        <= '0;
      ig_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      full_r      <= full_nxt;
      step_r      <= step_nxt;
      cl_r        <= cl_nxt;
      ig_r        <= ig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  bcse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.div_done = div_done;
  assign stat.pred_div = !sum_hi && !sum_lo && full_nz;
  assign stat.full_nz  = full_nz;
  assign stat.found    = found;
  assign stat.last     = (idx_r == LAST_IDX);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_soc   = out_soc_r;

  a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_soc_r <= SOC_FULL)
    else $error("state of charge above full scale");

endmodule
